// ----- rtl/lmrf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Longest monotone run finder package
// Shared compare result type and direction codes.
// ----------------------------------------------------------------------------
package lmrf_pkg;

    typedef struct packed {
        logic lt;
        logic gt;
    } t_cmp;

    localparam logic DIR_ASC  = 1'b0;
    localparam logic DIR_DESC = 1'b1;

endpackage : lmrf_pkg
`default_nettype wire

// ----- rtl/lmrf_cmp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Shared signed comparator
// Two's complement magnitude compare used for both run extension and judging.
// ----------------------------------------------------------------------------
module lmrf_cmp #(
    parameter int DATA_WIDTH = 16
) (
    input  logic signed [DATA_WIDTH-1:0] i_a,
    input  logic signed [DATA_WIDTH-1:0] i_b,
    output lmrf_pkg::t_cmp               o_cmp
);
    import lmrf_pkg::*;

    always_comb begin
        o_cmp.lt = (i_a < i_b);
        o_cmp.gt = (i_a > i_b);
    end

endmodule : lmrf_cmp
`default_nettype wire

// ----- rtl/longest_monotone_run_finder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Longest monotone run finder
// Stores a sequence of signed values and replays its longest monotone run.
// ----------------------------------------------------------------------------
// Usage:
//   Input: present i_value and i_last_in with start; the item transfers at a
//   clock edge where start is high and busy is low. busy stays high while the
//   item is processed.
//   Each item holds busy high while it is stepped, and also through a
//   judgement when it breaks the current run; a new item cannot transfer
//   while busy is high. One comparator is shared by the run extension check
//   and the best-run judgement, so a break needs the separate judgement.
//   The last item adds a final judgement, then the chosen run is read from
//   the element memory, one entry per cycle: results appear on o_run_value,
//   o_last_out, o_overflow with o_strobe high for one cycle each, read in
//   S_EMIT after the final judgement and registered, one per cycle, best-run length
//   results in total. busy drops in the cycle of the final result.
//   The receiver cannot stall; each strobed result is taken in its cycle.
//   Configuration: i_cfg_data transfers on i_cfg_valid; o_cfg_ready is always
//   high. Write it only while the block is idle.
//   Reset clears the sequence state and sets the direction to ascending; the
//   element memory needs no clearing.
// ----------------------------------------------------------------------------
module longest_monotone_run_finder #(
    parameter int MAX_LEN    = 64,
    parameter int DATA_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    input  logic                         i_last_in,
    output logic                         o_strobe,
    output logic signed [DATA_WIDTH-1:0] o_run_value,
    output logic                         o_last_out,
    output logic                         o_overflow,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_data
);
    import lmrf_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);
    localparam logic [CW-1:0] ONE_CNT = CW'(1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_STEP  = 4'b0010,
        S_JUDGE = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic                         r_direction;
    logic signed [DATA_WIDTH-1:0] r_value;
    logic                         r_last;
    logic [CW-1:0]                r_count, n_count;
    logic [AW-1:0]                r_run_start, n_run_start;
    logic [CW-1:0]                r_run_len, n_run_len;
    logic signed [DATA_WIDTH-1:0] r_run_first, n_run_first;
    logic [AW-1:0]                r_best_start, n_best_start;
    logic [CW-1:0]                r_best_len, n_best_len;
    logic signed [DATA_WIDTH-1:0] r_best_first, n_best_first;
    logic signed [DATA_WIDTH-1:0] r_prev, n_prev;
    logic                         r_ovf_seen, n_ovf_seen;
    logic                         r_break, n_break;
    logic [AW-1:0]                r_new_start, n_new_start;
    logic [AW-1:0]                r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]                r_emit_left, n_emit_left;
    logic                         r_strobe;
    logic                         r_last_out;
    logic                         r_ovf_out;
    logic signed [DATA_WIDTH-1:0] r_rd_data;

    logic signed [DATA_WIDTH-1:0] r_mem [MAX_LEN];

    logic signed [DATA_WIDTH-1:0] cmp_a;
    logic signed [DATA_WIDTH-1:0] cmp_b;
    t_cmp                         cmp_res;
    logic                         continues;
    logic                         better;
    logic                         store_en;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_run_value = r_rd_data;
    assign o_last_out  = r_last_out;
    assign o_overflow  = r_ovf_out;
    assign store_en    = (r_state == S_STEP) && (r_count < MAX_CNT);

    always_comb begin
        if (r_state == S_JUDGE) begin
            cmp_a = r_run_first;
            cmp_b = r_best_first;
        end else begin
            cmp_a = r_prev;
            cmp_b = r_value;
        end
    end

    lmrf_cmp #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_cmp(cmp_res)
    );

    assign continues = (r_direction == DIR_DESC) ? !cmp_res.lt : !cmp_res.gt;
    assign better    = (r_run_len != '0) &&
                       ((r_run_len > r_best_len) ||
                        ((r_run_len == r_best_len) &&
                         ((r_direction == DIR_DESC) ? cmp_res.gt : cmp_res.lt)));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_run_start  = r_run_start;
        n_run_len    = r_run_len;
        n_run_first  = r_run_first;
        n_best_start = r_best_start;
        n_best_len   = r_best_len;
        n_best_first = r_best_first;
        n_prev       = r_prev;
        n_ovf_seen   = r_ovf_seen;
        n_break      = r_break;
        n_new_start  = r_new_start;
        n_rd_ptr     = r_rd_ptr;
        n_emit_left  = r_emit_left;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (r_count < MAX_CNT) begin
                    n_prev  = r_value;
                    n_count = r_count + ONE_CNT;
                    if (r_count == '0) begin
                        n_run_start = '0;
                        n_run_len   = ONE_CNT;
                        n_run_first = r_value;
                    end else if (continues) begin
                        n_run_len = r_run_len + ONE_CNT;
                    end else begin
                        n_break     = 1'b1;
                        n_new_start = r_count[AW-1:0];
                    end
                end else begin
                    n_ovf_seen = 1'b1;
                end
                n_state = (n_break || r_last) ? S_JUDGE : S_IDLE;
            end
            S_JUDGE: begin
                if (better) begin
                    n_best_start = r_run_start;
                    n_best_len   = r_run_len;
                    n_best_first = r_run_first;
                end
                if (r_break) begin
                    n_break     = 1'b0;
                    n_run_start = r_new_start;
                    n_run_len   = ONE_CNT;
                    n_run_first = r_value;
                    n_state     = r_last ? S_JUDGE : S_IDLE;
                end else begin
                    n_rd_ptr    = n_best_start;
                    n_emit_left = n_best_len;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                n_rd_ptr    = r_rd_ptr + AW'(1);
                n_emit_left = r_emit_left - ONE_CNT;
                if (r_emit_left == ONE_CNT) begin
                    n_count      = '0;
                    n_run_start  = '0;
                    n_run_len    = '0;
                    n_run_first  = '0;
                    n_best_start = '0;
                    n_best_len   = '0;
                    n_best_first = '0;
                    n_prev       = '0;
                    n_ovf_seen   = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_direction  <= DIR_ASC;
            r_count      <= '0;
            r_run_start  <= '0;
            r_run_len    <= '0;
            r_run_first  <= '0;
            r_best_start <= '0;
            r_best_len   <= '0;
            r_best_first <= '0;
            r_prev       <= '0;
            r_ovf_seen   <= 1'b0;
            r_break      <= 1'b0;
            r_new_start  <= '0;
            r_rd_ptr     <= '0;
            r_emit_left  <= '0;
            r_strobe     <= 1'b0;
            r_last_out   <= 1'b0;
            r_ovf_out    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_run_start  <= n_run_start;
            r_run_len    <= n_run_len;
            r_run_first  <= n_run_first;
            r_best_start <= n_best_start;
            r_best_len   <= n_best_len;
            r_best_first <= n_best_first;
            r_prev       <= n_prev;
            r_ovf_seen   <= n_ovf_seen;
            r_break      <= n_break;
            r_new_start  <= n_new_start;
            r_rd_ptr     <= n_rd_ptr;
            r_emit_left  <= n_emit_left;
            r_strobe     <= (r_state == S_EMIT);
            r_last_out   <= (r_state == S_EMIT) && (r_emit_left == ONE_CNT);
            r_ovf_out    <= r_ovf_seen;
            if (i_cfg_valid && o_cfg_ready) begin
                r_direction <= i_cfg_data;
            end
        end
    end

    // hold the accepted item for the sequencer
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_value <= i_value;
            r_last  <= i_last_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_mem[r_count[AW-1:0]] <= r_value;
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

`ifndef SYNTHESIS
    a_accept_to_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_STEP))
        else $error("accepted item did not enter processing");

    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_EMIT))
        else $error("result strobe without a memory read");

    a_best_within_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_best_len <= r_count) && (r_run_len <= r_count))
        else $error("run length exceeds stored item count");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_emit_left != '0))
        else $error("emission with no results left");
`endif

endmodule : longest_monotone_run_finder
`default_nettype wire

// ----- tb/longest_monotone_run_finder_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Longest monotone run finder testbench
// Drives value sequences through the start/busy port and predicts the chosen
// run for each one. Every strobed run element is checked against that
// prediction. A short stimulus table comes first: single-item sequences
// with fixed expected values, ties and both directions. Random sequences
// follow, with varied shapes, direction changes and overlong sequences.
// ----------------------------------------------------------------------------
module longest_monotone_run_finder_test;
    import lmrf_pkg::*;

    localparam int MAX_LEN = 64;
    localparam int DW      = 16;

    typedef struct packed {
        logic                 dir;
        logic signed [DW-1:0] val;
        logic                 last;
        logic                 pin;
        logic signed [DW-1:0] exp_val;
    } t_stim_row;

    typedef struct {
        logic signed [DW-1:0] run_value;
        logic                 last_out;
        logic                 overflow;
    } t_run_elem;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic signed [DW-1:0] i_value     = '0;
    logic                 i_last_in   = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 i_cfg_data  = 1'b0;
    logic                 pin_on      = 1'b0;
    logic signed [DW-1:0] pin_val     = '0;
    logic                 busy;
    logic                 o_strobe;
    logic signed [DW-1:0] o_run_value;
    logic                 o_last_out;
    logic                 o_overflow;
    logic                 o_cfg_ready;

    longest_monotone_run_finder #(
        .MAX_LEN   (MAX_LEN),
        .DATA_WIDTH(DW)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_value    (i_value),
        .i_last_in  (i_last_in),
        .o_strobe   (o_strobe),
        .o_run_value(o_run_value),
        .o_last_out (o_last_out),
        .o_overflow (o_overflow),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Run tracker state
    logic signed [DW-1:0] elem_mem [MAX_LEN];
    int unsigned          item_cnt   = 0;
    int unsigned          run_st     = 0;
    int unsigned          run_len    = 0;
    int unsigned          best_st    = 0;
    int unsigned          best_len   = 0;
    logic signed [DW-1:0] best_first = '0;
    logic signed [DW-1:0] prev_val   = '0;
    logic                 ovf_seen   = 1'b0;
    logic                 dir_reg    = DIR_ASC;

    t_run_elem pending_run_elems [$];
    int        items_taken = 0;
    int        cfg_taken   = 0;
    int        fail_count  = 0;
    logic      dir_now     = DIR_ASC;
    logic      calm        = 1'b0;

    function automatic bit extends_run(input logic signed [DW-1:0] a,
                                       input logic signed [DW-1:0] b);
        return (dir_reg == DIR_DESC) ? (a >= b) : (a <= b);
    endfunction

    function automatic void close_run();
        logic signed [DW-1:0] first;
        bit                   better;
        if (run_len == 0) return;
        first = elem_mem[run_st];
        if (run_len > best_len) better = 1'b1;
        else if (run_len < best_len) better = 1'b0;
        else if (dir_reg == DIR_DESC) better = first > best_first;
        else better = first < best_first;
        if (better) begin
            best_st    = run_st;
            best_len   = run_len;
            best_first = first;
        end
    endfunction

    function automatic void track_runs(input logic signed [DW-1:0] v, input logic last,
                                       input logic pin, input logic signed [DW-1:0] pv);
        t_run_elem e;
        if (item_cnt < MAX_LEN) begin
            elem_mem[item_cnt] = v;
            if (item_cnt == 0) begin
                run_st  = 0;
                run_len = 1;
            end else if (extends_run(prev_val, v)) begin
                run_len++;
            end else begin
                close_run();
                run_st  = item_cnt;
                run_len = 1;
            end
            prev_val = v;
            item_cnt++;
        end else begin
            ovf_seen = 1'b1;
        end
        if (!last) return;
        close_run();
        if (pin) begin
            e.run_value = pv;
            e.last_out  = 1'b1;
            e.overflow  = 1'b0;
            pending_run_elems.insert(pending_run_elems.size(), e);
        end else begin
            for (int unsigned k = 0; k < best_len; k++) begin
                e.run_value = elem_mem[(best_st + k) % MAX_LEN];
                e.last_out  = (k + 1 == best_len);
                e.overflow  = ovf_seen;
                pending_run_elems.insert(pending_run_elems.size(), e);
            end
        end
        item_cnt   = 0;
        run_st     = 0;
        run_len    = 0;
        best_st    = 0;
        best_len   = 0;
        best_first = '0;
        prev_val   = '0;
        ovf_seen   = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_run_elem e;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending_run_elems.size() == 0) begin
                    $display("%0t: unexpected run element: expected none, got %0d/%0b/%0b",
                             $time, o_run_value, o_last_out, o_overflow);
                    fail_count++;
                end else begin
                    e = pending_run_elems.pop_front();
                    if (o_run_value !== e.run_value || o_last_out !== e.last_out ||
                        o_overflow !== e.overflow) begin
                        $display("%0t: run element mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                 $time, e.run_value, e.last_out, e.overflow,
                                 o_run_value, o_last_out, o_overflow);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                dir_reg = i_cfg_data;
                cfg_taken++;
            end
            if (start && !busy) begin
                track_runs(i_value, i_last_in, pin_on, pin_val);
                items_taken++;
            end
        end
    end

    task automatic push_item(input logic signed [DW-1:0] v, input logic last,
                             input logic pin, input logic signed [DW-1:0] pv);
        int n0;
        while (!calm && $urandom_range(99) < 37) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        n0 = items_taken;
        start     <= 1'b1;
        i_value   <= v;
        i_last_in <= last;
        pin_on    <= pin;
        pin_val   <= pv;
        do @(negedge i_clk); while (items_taken == n0);
    endtask

    task automatic drop_start();
        start <= 1'b0;
        @(negedge i_clk);
    endtask

    // Write only once the block has drained
    task automatic write_dir(input logic d);
        int n0;
        while (pending_run_elems.size() != 0 || busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        n0 = cfg_taken;
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= d;
        do @(negedge i_clk); while (cfg_taken == n0);
        i_cfg_valid <= 1'b0;
        dir_now = d;
    endtask

    t_stim_row directed_rows [24] = '{
        '{DIR_ASC,  16'sd32767, 1'b1, 1'b1, 16'sd32767},
        '{DIR_ASC,  16'sh8000,  1'b1, 1'b1, 16'sh8000},
        '{DIR_ASC,  16'sd0,     1'b1, 1'b1, 16'sd0},
        '{DIR_ASC,  16'sh8000,  1'b0, 1'b0, 16'sd0},
        '{DIR_ASC,  -16'sd5,    1'b0, 1'b0, 16'sd0},
        '{DIR_ASC,  -16'sd5,    1'b0, 1'b0, 16'sd0},
        '{DIR_ASC,  16'sd32767, 1'b0, 1'b0, 16'sd0},
        '{DIR_ASC,  -16'sd1,    1'b0, 1'b0, 16'sd0},
        '{DIR_ASC,  16'sd0,     1'b0, 1'b0, 16'sd0},
        '{DIR_ASC,  16'sd1,     1'b0, 1'b0, 16'sd0},
        '{DIR_ASC,  16'sd2,     1'b1, 1'b0, 16'sd0},
        '{DIR_ASC,  16'sd5,     1'b0, 1'b0, 16'sd0},
        '{DIR_ASC,  16'sd6,     1'b0, 1'b0, 16'sd0},
        '{DIR_ASC,  16'sd1,     1'b0, 1'b0, 16'sd0},
        '{DIR_ASC,  16'sd2,     1'b1, 1'b0, 16'sd0},
        '{DIR_DESC, -16'sd1,    1'b1, 1'b1, -16'sd1},
        '{DIR_DESC, 16'sd3,     1'b0, 1'b0, 16'sd0},
        '{DIR_DESC, 16'sd1,     1'b0, 1'b0, 16'sd0},
        '{DIR_DESC, 16'sd9,     1'b0, 1'b0, 16'sd0},
        '{DIR_DESC, 16'sd2,     1'b0, 1'b0, 16'sd0},
        '{DIR_DESC, 16'sd9,     1'b1, 1'b0, 16'sd0},
        '{DIR_DESC, 16'sd7,     1'b0, 1'b0, 16'sd0},
        '{DIR_DESC, 16'sd7,     1'b0, 1'b0, 16'sd0},
        '{DIR_DESC, 16'sd7,     1'b1, 1'b0, 16'sd0}
    };

    initial begin
        int        seq_no;
        int        items_sent;
        int        seq_len;
        int        shape;
        int        walk;
        int        step;
        logic [DW-1:0] pick;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_dir(DIR_ASC);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].dir != dir_now) begin
                drop_start();
                write_dir(directed_rows[r].dir);
            end
            push_item(directed_rows[r].val, directed_rows[r].last,
                      directed_rows[r].pin, directed_rows[r].exp_val);
        end

        seq_no     = 0;
        items_sent = 0;
        while (items_sent < 136) begin
            calm = (seq_no >= 6 && seq_no < 12);
            if ($urandom_range(3) == 0) begin
                drop_start();
                write_dir(1'($urandom_range(1)));
            end
            if (seq_no == 2) seq_len = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
            else seq_len = $urandom_range(1, 10);
            shape = $urandom_range(3);
            walk  = $urandom_range(65535);
            for (int k = 0; k < seq_len; k++) begin
                case (shape)
                    0: pick = DW'($urandom_range(65535));
                    1: pick = DW'($urandom_range(8) - 4);
                    2: begin
                        // drift with the direction, with the odd reversal
                        step = $urandom_range(3);
                        if ($urandom_range(4) == 0) step = -step - 1;
                        walk = (dir_now == DIR_DESC) ? walk - step : walk + step;
                        pick = walk[DW-1:0];
                    end
                    default: begin
                        case ($urandom_range(3))
                            0: pick = 16'h8000;
                            1: pick = 16'h7fff;
                            2: pick = 16'h0000;
                            default: pick = 16'hffff;
                        endcase
                    end
                endcase
                push_item(pick, k == seq_len - 1, 1'b0, '0);
            end
            items_sent += seq_len;
            seq_no++;
        end

        calm = 1'b0;
        drop_start();
        while (pending_run_elems.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
